// ===== rtl/tws_pkg.sv =====
// Package with shared types, codes and constants of the three-wire serial master.
`default_nettype none
package tws_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SETUP_W = 10;
  localparam int unsigned HALF_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Input item function codes.
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SETUP_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS  = 2'd2;

  // Configuration reset values.
  localparam logic [SETUP_W-1:0] SETUP_TICKS_RST = 10'd10;
  localparam logic [HALF_W-1:0]  LOW_TICKS_RST   = 8'd1;
  localparam logic [HALF_W-1:0]  HIGH_TICKS_RST  = 8'd9;

  // Command byte bit 0 selects read or write.
  localparam logic [BYTE_W-1:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [BYTE_W-1:0] ADDR_RD_BIT  = 8'h01;

  typedef struct packed {
    logic [SETUP_W-1:0] setup_ticks;
    logic [HALF_W-1:0]  low_ticks;
    logic [HALF_W-1:0]  high_ticks;
  } tws_cfg_t;

  typedef struct packed {
    logic              ce_out;
    logic              sclk_out;
    logic              sda_out;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              rejected;
  } tws_res_t;

endpackage
`default_nettype wire

// ===== rtl/tws_in_if.sv =====
// Input channel interface: one tick or command beat per handshake.
`default_nettype none
interface tws_in_if;
  import tws_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] reg_addr;
  logic [BYTE_W-1:0] write_data;
  logic              sda_in;

  modport source (output valid, output func, output reg_addr, output write_data,
                  output sda_in, input ready);
  modport sink   (input valid, input func, input reg_addr, input write_data,
                  input sda_in, output ready);
endinterface
`default_nettype wire

// ===== rtl/tws_out_if.sv =====
// Result channel interface: pin levels and status for each beat.
`default_nettype none
interface tws_out_if;
  import tws_pkg::*;

  logic              valid;
  logic              ready;
  logic              ce_out;
  logic              sclk_out;
  logic              sda_out;
  logic              sda_drive;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_byte;
  logic              rejected;

  modport source (output valid, output ce_out, output sclk_out, output sda_out,
                  output sda_drive, output busy_res, output done_res,
                  output read_byte, output rejected, input ready);
  modport sink   (input valid, input ce_out, input sclk_out, input sda_out,
                  input sda_drive, input busy_res, input done_res,
                  input read_byte, input rejected, output ready);
endinterface
`default_nettype wire

// ===== rtl/tws_seq.sv =====
// Transfer sequencer: phase, bit and tick counters, shift registers.
`default_nettype none
module tws_seq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      fire,
  input  wire logic [tws_pkg::FUNC_W-1:0] func,
  input  wire logic [tws_pkg::BYTE_W-1:0] reg_addr,
  input  wire logic [tws_pkg::BYTE_W-1:0] write_data,
  input  wire logic                      sda_in,
  input  wire tws_pkg::tws_cfg_t         cfg,
  output tws_pkg::tws_res_t              res
);
  import tws_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_LOW   = 2'd2,
    PH_HIGH  = 2'd3
  } phase_t;

  localparam logic [4:0] CELLS_TOTAL = 5'd16;
  localparam logic [4:0] CMD_CELLS   = 5'd8;

  phase_t              phase_r, phase_nxt;
  logic [4:0]          bit_index_r, bit_index_nxt;
  logic [SETUP_W-1:0]  tick_r, tick_nxt;
  logic [2*BYTE_W-1:0] out_shift_r, out_shift_nxt;
  logic [BYTE_W-1:0]   in_shift_r, in_shift_nxt;
  logic                is_read_r, is_read_nxt;

  logic [SETUP_W-1:0]  tick_inc;
  logic [4:0]          bit_inc;
  logic                is_cmd;
  logic                done;
  logic                rej;
  logic                reading;

  assign tick_inc = tick_r + SETUP_W'(1);
  assign bit_inc  = bit_index_r + 5'd1;
  assign is_cmd   = (func == FUNC_WRITE) || (func == FUNC_READ);

  always_comb begin
    phase_nxt     = phase_r;
    bit_index_nxt = bit_index_r;
    tick_nxt      = tick_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    is_read_nxt   = is_read_r;
    done          = 1'b0;
    rej           = 1'b0;
    if (is_cmd) begin
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        is_read_nxt = (func == FUNC_READ);
        if (func == FUNC_READ) begin
          out_shift_nxt = {BYTE_W'(0), reg_addr | ADDR_RD_BIT};
        end else begin
          out_shift_nxt = {write_data, reg_addr & ADDR_WR_MASK};
        end
        in_shift_nxt  = '0;
        bit_index_nxt = '0;
        tick_nxt      = '0;
        phase_nxt     = PH_SETUP;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_SETUP: begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg.setup_ticks) begin
            phase_nxt = PH_LOW;
            tick_nxt  = '0;
          end
        end
        PH_LOW: begin
          tick_nxt = tick_inc;
          if (tick_inc >= SETUP_W'(cfg.low_ticks)) begin
            if (is_read_r && (bit_index_r >= CMD_CELLS)) begin
              in_shift_nxt = {sda_in, in_shift_r[BYTE_W-1:1]};
            end
            phase_nxt = PH_HIGH;
            tick_nxt  = '0;
          end
        end
        PH_HIGH: begin
          tick_nxt = tick_inc;
          if (tick_inc >= SETUP_W'(cfg.high_ticks)) begin
            bit_index_nxt = bit_inc;
            out_shift_nxt = {1'b0, out_shift_r[2*BYTE_W-1:1]};
            tick_nxt      = '0;
            if (bit_inc >= CELLS_TOTAL) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_LOW;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pin levels reflect the state after this beat has been applied.
  assign reading = is_read_nxt && (bit_index_nxt >= CMD_CELLS);

  always_comb begin
    res = '0;
    res.busy_res = (phase_nxt != PH_IDLE);
    res.done_res = done;
    res.rejected = rej;
    if (phase_nxt == PH_SETUP) begin
      res.sda_drive = 1'b1;
    end else if ((phase_nxt == PH_LOW) || (phase_nxt == PH_HIGH)) begin
      res.ce_out   = 1'b1;
      res.sclk_out = (phase_nxt == PH_HIGH);
      if (!reading) begin
        res.sda_drive = 1'b1;
        res.sda_out   = out_shift_nxt[0];
      end
    end
    if (done && is_read_nxt) begin
      res.read_byte = in_shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_index_r <= '0;
      tick_r      <= '0;
      out_shift_r <= '0;
      in_shift_r  <= '0;
      is_read_r   <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      bit_index_r <= bit_index_nxt;
      tick_r      <= tick_nxt;
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      is_read_r   <= is_read_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/three_wire_rtc_serial_master_top.sv =====
// Top level of the three-wire serial master: config registers, sequencer, result register.
// Each accepted beat's result is registered and offered on the output in the next cycle.
// Throughput: one beat per cycle; the sequencer's next-state logic feeds the
// result register directly, so a new beat is taken whenever that register is
// empty or is being drained in the same cycle.
// Reset: synchronous, active-low rst_n returns the sequencer to idle, empties
// the result register and loads the timing registers with 10, 1 and 9 ticks.
`default_nettype none
module three_wire_rtc_serial_master_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  tws_in_if.sink                             in_bus,
  tws_out_if.source                          out_bus,
  input  wire logic                          cfg_we,
  input  wire logic [tws_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [tws_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tws_pkg::*;

  tws_cfg_t cfg_r;
  tws_res_t res_comb;
  tws_res_t res_r;
  logic     out_valid_r;
  logic     in_fire;

  // The result register frees up when empty or when its beat leaves this cycle.
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // Timing registers. Writes are for the user to make only while the block is
  // idle; the block does not enforce this. An unused index is simply ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks <= SETUP_TICKS_RST;
      cfg_r.low_ticks   <= LOW_TICKS_RST;
      cfg_r.high_ticks  <= HIGH_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SETUP_TICKS: cfg_r.setup_ticks <= cfg_wdata[SETUP_W-1:0];
        CFG_LOW_TICKS:   cfg_r.low_ticks   <= cfg_wdata[HALF_W-1:0];
        CFG_HIGH_TICKS:  cfg_r.high_ticks  <= cfg_wdata[HALF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer advances only on an accepted beat; ticks and commands
  // alike produce exactly one result.
  tws_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .func       (in_bus.func),
    .reg_addr   (in_bus.reg_addr),
    .write_data (in_bus.write_data),
    .sda_in     (in_bus.sda_in),
    .cfg        (cfg_r),
    .res        (res_comb)
  );

  // Output register: holds the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_comb;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.ce_out    = res_r.ce_out;
  assign out_bus.sclk_out  = res_r.sclk_out;
  assign out_bus.sda_out   = res_r.sda_out;
  assign out_bus.sda_drive = res_r.sda_drive;
  assign out_bus.busy_res  = res_r.busy_res;
  assign out_bus.done_res  = res_r.done_res;
  assign out_bus.read_byte = res_r.read_byte;
  assign out_bus.rejected  = res_r.rejected;

endmodule
`default_nettype wire

// ===== tb/three_wire_rtc_serial_master_top_test.sv =====
// Self-checking testbench for the three-wire serial master: predicts pin levels per beat.
`default_nettype none
module three_wire_rtc_serial_master_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tws_pkg::*;

  // Function code three has no meaning of its own; the block treats it as a tick.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  // A transfer is sixteen bit cells: eight of command byte, eight of data.
  localparam int CELL_COUNT = 16;
  localparam int CMD_CELLS  = 8;
  // Generous ceiling on the length of a run.
  localparam int CYCLE_LIMIT = 400000;

  // Sequencer phases as the testbench tracks them.
  typedef enum logic [1:0] {SQ_IDLE, SQ_SETUP, SQ_CLK_LO, SQ_CLK_HI} seq_phase_t;
  // How the data line is driven back to the master on ticks.
  typedef enum int {SDA_LOW, SDA_HIGH, SDA_TOGGLE, SDA_RANDOM} sda_pattern_t;

  // Tracks the sequencer beat by beat and holds the pin levels each accepted
  // beat must produce, oldest first.
  class pin_tracker;
    tws_cfg_t   timing;
    seq_phase_t state;
    logic [4:0] cell_no;
    logic [9:0] ticks;
    logic [15:0] tx_bits;
    logic [7:0] rx_bits;
    bit         read_xfer;
    tws_res_t   levels_due[$];
    int errors, checked, writes_done, reads_done, refused;

    function new();
      timing.setup_ticks = SETUP_TICKS_RST;
      timing.low_ticks   = LOW_TICKS_RST;
      timing.high_ticks  = HIGH_TICKS_RST;
      state     = SQ_IDLE;
      cell_no   = '0;
      ticks     = '0;
      tx_bits   = '0;
      rx_bits   = '0;
      read_xfer = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SETUP_TICKS: timing.setup_ticks = val;
        CFG_LOW_TICKS:   timing.low_ticks   = val[HALF_W-1:0];
        CFG_HIGH_TICKS:  timing.high_ticks  = val[HALF_W-1:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return state != SQ_IDLE;
    endfunction

    // The data line is released during the data byte of a read.
    function bit rx_cell();
      return read_xfer && cell_no >= CMD_CELLS;
    endfunction

    // One tick of time; returns 1 when it completes the transfer.
    function bit clock_tick(logic sda);
      bit fin;
      fin = 1'b0;
      case (state)
        SQ_SETUP: begin
          ticks = ticks + 1'b1;
          if (ticks >= timing.setup_ticks) begin
            state = SQ_CLK_LO;
            ticks = '0;
          end
        end
        SQ_CLK_LO: begin
          ticks = ticks + 1'b1;
          if (ticks >= timing.low_ticks) begin
            if (rx_cell()) rx_bits = {sda, rx_bits[7:1]};
            state = SQ_CLK_HI;
            ticks = '0;
          end
        end
        SQ_CLK_HI: begin
          ticks = ticks + 1'b1;
          if (ticks >= timing.high_ticks) begin
            cell_no = cell_no + 1'b1;
            tx_bits = tx_bits >> 1;
            ticks   = '0;
            if (cell_no >= CELL_COUNT) begin
              state = SQ_IDLE;
              fin   = 1'b1;
            end else begin
              state = SQ_CLK_LO;
            end
          end
        end
        default: ;
      endcase
      return fin;
    endfunction

    function void accept_beat(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] addr,
                              logic [BYTE_W-1:0] wdata, logic sda);
      tws_res_t want;
      bit fin;
      want = '0;
      fin  = 1'b0;
      if (func == FUNC_WRITE || func == FUNC_READ) begin
        if (busy()) begin
          want.rejected = 1'b1;
          refused++;
        end else begin
          read_xfer = (func == FUNC_READ);
          tx_bits   = read_xfer ? {8'h00, addr | ADDR_RD_BIT} : {wdata, addr & ADDR_WR_MASK};
          rx_bits   = '0;
          cell_no   = '0;
          ticks     = '0;
          state     = SQ_SETUP;
        end
      end else begin
        fin = clock_tick(sda);
      end
      case (state)
        SQ_SETUP: want.sda_drive = 1'b1;
        SQ_CLK_LO, SQ_CLK_HI: begin
          want.ce_out   = 1'b1;
          want.sclk_out = (state == SQ_CLK_HI);
          if (!rx_cell()) begin
            want.sda_drive = 1'b1;
            want.sda_out   = tx_bits[0];
          end
        end
        default: ;
      endcase
      want.busy_res = busy();
      want.done_res = fin;
      if (fin && read_xfer) want.read_byte = rx_bits;
      if (fin) begin
        if (read_xfer) reads_done++;
        else writes_done++;
      end
      levels_due.push_back(want);
    endfunction

    task report(string what);
      $display("%0t ns: mismatch, %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task match_levels(tws_res_t got);
      tws_res_t want;
      if (levels_due.size() == 0) begin
        report("result beat arrived with nothing expected");
        return;
      end
      want = levels_due.pop_front();
      checked++;
      check_field("ce_out",    got.ce_out,    want.ce_out);
      check_field("sclk_out",  got.sclk_out,  want.sclk_out);
      check_field("sda_out",   got.sda_out,   want.sda_out);
      check_field("sda_drive", got.sda_drive, want.sda_drive);
      check_field("busy_res",  got.busy_res,  want.busy_res);
      check_field("done_res",  got.done_res,  want.done_res);
      check_field("read_byte", got.read_byte, want.read_byte);
      check_field("rejected",  got.rejected,  want.rejected);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tws_in_if  in_bus();
  tws_out_if out_bus();

  // Idle percentages of the two sides; changed by the main sequence per mode.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // Long receiver hold-off, requested once by the main sequence.
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;
  // Beats that can change the sequencer; ticks while idle are not counted.
  int beats_sent = 0;

  pin_tracker book = new();

  three_wire_rtc_serial_master_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side. Everything is sampled right at the rising edge, before the
  // block's own nonblocking updates land, and ready is changed by NBA only.
  initial begin
    tws_res_t got;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got.ce_out    = out_bus.ce_out;
        got.sclk_out  = out_bus.sclk_out;
        got.sda_out   = out_bus.sda_out;
        got.sda_drive = out_bus.sda_drive;
        got.busy_res  = out_bus.busy_res;
        got.done_res  = out_bus.done_res;
        got.read_byte = out_bus.read_byte;
        got.rejected  = out_bus.rejected;
        book.match_levels(got);
      end
      out_bus.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Once requested, the receiver is held off for a long stretch so that the
  // result register fills and the block has to push back on its input.
  initial begin
    while (!hold_go) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offers one input beat, with random idle cycles ahead of it, and hands it
  // to the tracker once it is taken. valid stays high after the handshake so
  // that back-to-back beats need no extra assignment in the same step.
  task automatic send_beat(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] addr,
                           logic [BYTE_W-1:0] wdata, logic sda);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= func;
    in_bus.reg_addr   <= addr;
    in_bus.write_data <= wdata;
    in_bus.sda_in     <= sda;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (book.busy() || func == FUNC_WRITE || func == FUNC_READ) beats_sent++;
    book.accept_beat(func, addr, wdata, sda);
  endtask

  // Feeds ticks until the running transfer completes. With noise enabled, a
  // few stray start commands (which must be refused) and spare function
  // codes are mixed in.
  task automatic run_out(sda_pattern_t pattern, bit noisy);
    int k;
    logic sda;
    while (book.busy()) begin
      k = noisy ? $urandom_range(99) : 99;
      case (pattern)
        SDA_LOW:    sda = 1'b0;
        SDA_HIGH:   sda = 1'b1;
        SDA_TOGGLE: sda = book.cell_no[0];
        default:    sda = 1'($urandom_range(1));
      endcase
      if (k < 3)
        send_beat($urandom_range(1) ? FUNC_READ : FUNC_WRITE, BYTE_W'($urandom_range(255)),
                  BYTE_W'($urandom_range(255)), sda);
      else if (k < 6)
        send_beat(FUNC_SPARE, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                  sda);
      else
        send_beat(FUNC_TICK, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                  sda);
    end
  endtask

  // Stops offering beats and waits until every expected result is back, then
  // gives the one-deep result register time to settle.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (book.levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_poke(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.set_reg(idx, val);
  endtask

  // Rewrites all three timing registers; only called with the block idle.
  task automatic set_timing(logic [CFG_DATA_W-1:0] setup_val, logic [CFG_DATA_W-1:0] low_val,
                            logic [CFG_DATA_W-1:0] high_val);
    cfg_poke(CFG_SETUP_TICKS, setup_val);
    cfg_poke(CFG_LOW_TICKS, low_val);
    cfg_poke(CFG_HIGH_TICKS, high_val);
    cfg_we <= 1'b0;
  endtask

  // Mostly complete transfers with random command, data and read-back bits;
  // the remainder is loose beats of any function code.
  task automatic random_traffic(int count);
    int first;
    first = beats_sent;
    while (beats_sent - first < count) begin
      if ($urandom_range(99) < 85 && !book.busy()) begin
        send_beat($urandom_range(1) ? FUNC_READ : FUNC_WRITE, BYTE_W'($urandom_range(255)),
                  BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        run_out(SDA_RANDOM, 1'b1);
      end else begin
        send_beat(FUNC_W'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                  BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    run_out(SDA_RANDOM, 1'b1);
  endtask

  // Main sequence: reset, directed transfers, random phases under three idle
  // patterns, then one transfer with oversized register writes.
  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_addr          <= '0;
    cfg_wdata         <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.func       <= FUNC_TICK;
    in_bus.reg_addr   <= '0;
    in_bus.write_data <= '0;
    in_bus.sda_in     <= 1'b0;
    tx_idle_pct = 7;
    rx_idle_pct = 68;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset timing. A tick and a spare code while idle must do nothing. A
    // write to the all-ones address with a zero byte is then interrupted by
    // a read, a write and a spare code, of which both starts are refused.
    send_beat(FUNC_TICK, 8'hFF, 8'hFF, 1'b1);
    send_beat(FUNC_SPARE, 8'hFF, 8'hFF, 1'b1);
    send_beat(FUNC_WRITE, 8'hFF, 8'h00, 1'b0);
    repeat (20) send_beat(FUNC_TICK, 8'h00, 8'h00, 1'b0);
    send_beat(FUNC_READ, 8'h00, 8'hFF, 1'b1);
    send_beat(FUNC_WRITE, 8'h00, 8'hFF, 1'b1);
    send_beat(FUNC_SPARE, 8'h00, 8'h00, 1'b0);
    run_out(SDA_HIGH, 1'b0);
    // A read from address zero with the line held high must return all ones.
    send_beat(FUNC_READ, 8'h00, 8'hFF, 1'b1);
    run_out(SDA_HIGH, 1'b0);
    settle();

    // Zero in every timing register must behave as one tick.
    set_timing(10'd0, 10'd0, 10'd0);
    send_beat(FUNC_WRITE, 8'h00, 8'hFF, 1'b1);
    run_out(SDA_LOW, 1'b0);
    send_beat(FUNC_READ, 8'hFE, 8'h00, 1'b0);
    run_out(SDA_TOGGLE, 1'b0);
    send_beat(FUNC_READ, 8'h55, 8'hAA, 1'b1);
    run_out(SDA_LOW, 1'b0);
    send_beat(FUNC_WRITE, 8'hAA, 8'h55, 1'b0);
    run_out(SDA_RANDOM, 1'b1);
    settle();

    // Random phases: the first pair with a slow receiver, the second with a
    // slow sender, the last with no idling and one long receiver hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        tx_idle_pct = 68;
        rx_idle_pct = 7;
      end
      if (ph == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go <= 1'b1;
      end
      if (ph == 1)
        set_timing(CFG_DATA_W'($urandom_range(20, 40)), 10'd1,
                   CFG_DATA_W'($urandom_range(4, 8)));
      else
        set_timing(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 2)),
                   CFG_DATA_W'($urandom_range(1, 3)));
      random_traffic(50);
      settle();
    end

    // Bits above the 8-bit registers are dropped, leaving two low ticks and
    // one high tick per cell.
    set_timing(10'd40, 10'h302, 10'h301);
    send_beat(FUNC_READ, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
              1'($urandom_range(1)));
    run_out(SDA_RANDOM, 1'b1);
    settle();

    $display("Checked %0d result beats: %0d writes and %0d reads completed, %0d starts refused.",
             book.checked, book.writes_done, book.reads_done, book.refused);
    $display("Timing ran from zero-valued registers to oversized writes under three idle mixes.");
    if (book.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/tws_pkg.sv
rtl/tws_in_if.sv
rtl/tws_out_if.sv
rtl/tws_seq.sv
rtl/three_wire_rtc_serial_master_top.sv
tb/three_wire_rtc_serial_master_top_test.sv
